/* rtl/hid_descriptor_feature_scanner_defines.svh */
// ----------------------------------------------------------------------------
// HID descriptor feature scanner - assertion macros
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef HID_DESCRIPTOR_FEATURE_SCANNER_DEFINES_SVH
`define HID_DESCRIPTOR_FEATURE_SCANNER_DEFINES_SVH

// Same-cycle implication, off during reset
`define HDFS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hdfs same-cycle check failed");

// Next-cycle implication, off during reset
`define HDFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hdfs next-cycle check failed");

// Next-cycle implication, checked through reset as well
`define HDFS_ASSERT_NEXT_ANY(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hdfs reset check failed");

`endif

/* rtl/hdfs_pkg.sv */
// ----------------------------------------------------------------------------
// hdfs_pkg
// Types, item codes and helpers shared by the descriptor feature scanner.
// ----------------------------------------------------------------------------
package hdfs_pkg;

  // Descriptor word in, result word out
  typedef struct packed {
    logic [7:0] desc_byte;
    logic       last_byte;
  } desc_t;

  typedef struct packed {
    logic has_feature;
    logic ended_inside_item;
  } result_t;

  // Input register contents handed to the parser
  typedef struct packed {
    logic  valid;
    desc_t item;
  } stage_t;

  // Item prefix codes
  localparam logic [7:0] LONG_PREFIX = 8'hFE;
  localparam logic [3:0] TAG_FEATURE = 4'hB;
  localparam logic [1:0] TYPE_MAIN   = 2'b00;

  // Parse phases
  localparam logic [1:0] PH_PREFIX   = 2'd0;
  localparam logic [1:0] PH_LONG_LEN = 2'd1;
  localparam logic [1:0] PH_LONG_TAG = 2'd2;
  localparam logic [1:0] PH_DATA     = 2'd3;

  // Short item data length from the size code
  function automatic logic [2:0] data_size(input logic [1:0] code);
    logic [2:0] len;
    case (code)
      2'd0:    len = 3'd0;
      2'd1:    len = 3'd1;
      2'd2:    len = 3'd2;
      default: len = 3'd4;
    endcase
    return len;
  endfunction

endpackage

/* rtl/hid_descriptor_feature_scanner.sv */
// ----------------------------------------------------------------------------
// hid_descriptor_feature_scanner
// Walks a HID report descriptor word by word and reports a Feature item.
// ----------------------------------------------------------------------------
// Path: a last word passes the input register, then the result register.
// Throughput: one descriptor word per cycle unless a held result stalls a last word;
//   the walker update sits between the input register and the result register.
// Reset: synchronous rst empties both registers and puts the walker at
//   "expect prefix"; the walker also returns there after every last word.
module hid_descriptor_feature_scanner
  import hdfs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    desc_valid,
  output logic    desc_stall,
  input  desc_t   desc,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  stage_t stage;
  logic   advance;

  hdfs_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc_stall (desc_stall),
    .desc       (desc),
    .advance    (advance),
    .stage      (stage)
  );

  hdfs_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .stage        (stage),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

/* rtl/hdfs_in_stage.sv */
// ----------------------------------------------------------------------------
// hdfs_in_stage
// Input register for descriptor words; holds a word while the parser waits.
// ----------------------------------------------------------------------------
module hdfs_in_stage
  import hdfs_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   desc_valid,
  output logic   desc_stall,
  input  desc_t  desc,
  input  logic   advance,
  output stage_t stage
);

  logic  valid;
  logic  valid_next;
  desc_t item;
  logic  load;

  // Stall only while a held word cannot move on
  assign desc_stall = valid && !advance;
  assign load       = desc_valid && !desc_stall;

  always_comb begin
    valid_next = valid;
    if (load) begin
      valid_next = 1'b1;
    end else if (advance) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (load) begin
      item <= desc;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = item;

endmodule

/* rtl/hdfs_parser.sv */
// ----------------------------------------------------------------------------
// hdfs_parser
// Item walker state and result register; one descriptor word per cycle unless a held result blocks.
// ----------------------------------------------------------------------------
module hdfs_parser
  import hdfs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  stage_t  stage,
  output logic    advance,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [7:0] skip;
  logic [7:0] skip_next;
  logic       seen;
  logic       seen_next;
  logic       result_valid_next;
  result_t    result_next;
  logic [7:0] b;
  logic [2:0] len;
  logic       last;

  assign b    = stage.item.desc_byte;
  assign last = stage.item.last_byte;
  assign len  = data_size(b[1:0]);

  // A last word waits only when the result register is still held
  assign advance = stage.valid && !(last && result_valid && result_stall);

  // Walk one word of the item structure
  always_comb begin
    phase_next = phase;
    skip_next  = skip;
    seen_next  = seen;
    if (!seen) begin
      unique case (phase)
        PH_PREFIX: begin
          if (b == LONG_PREFIX) begin
            phase_next = PH_LONG_LEN;
          end else if (b[3:2] == TYPE_MAIN && b[7:4] == TAG_FEATURE) begin
            seen_next = 1'b1;
          end else if (len != 3'd0) begin
            skip_next  = {5'd0, len};
            phase_next = PH_DATA;
          end
        end
        PH_LONG_LEN: begin
          skip_next  = b;
          phase_next = PH_LONG_TAG;
        end
        PH_LONG_TAG: begin
          phase_next = (skip != 8'd0) ? PH_DATA : PH_PREFIX;
        end
        default: begin
          if (skip > 8'd1) begin
            skip_next = skip - 8'd1;
          end else begin
            skip_next  = 8'd0;
            phase_next = PH_PREFIX;
          end
        end
      endcase
    end
    result_next.has_feature       = seen_next;
    result_next.ended_inside_item = !seen_next && (phase_next != PH_PREFIX);
  end

  // Update walker; clear after the last word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_PREFIX;
      skip  <= 8'd0;
      seen  <= 1'b0;
    end else if (advance) begin
      if (last) begin
        phase <= PH_PREFIX;
        skip  <= 8'd0;
        seen  <= 1'b0;
      end else begin
        phase <= phase_next;
        skip  <= skip_next;
        seen  <= seen_next;
      end
    end
  end

  // Result register: load on last word, drop once taken
  always_comb begin
    result_valid_next = result_valid;
    if (advance && last) begin
      result_valid_next = 1'b1;
    end else if (!result_stall) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last) begin
      result <= result_next;
    end
  end

endmodule

/* rtl/hdfs_checker.sv */
// ----------------------------------------------------------------------------
// hdfs_checker
// Port-level checks on the descriptor feature scanner, bound to the top.
// ----------------------------------------------------------------------------
`include "hid_descriptor_feature_scanner_defines.svh"

module hdfs_checker
  import hdfs_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    desc_valid,
  input logic    desc_stall,
  input desc_t   desc,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // Held result stays put
  `HDFS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

  // A found feature never reports a partial item
  `HDFS_ASSERT_SAME(a_flags_exclusive, result_valid, !(result.has_feature && result.ended_inside_item))

  // Input back-pressure only comes from a held result
  `HDFS_ASSERT_SAME(a_stall_cause, desc_stall, result_valid && result_stall)

  // Reset empties the result register
  `HDFS_ASSERT_NEXT_ANY(a_reset_empty, rst, !result_valid && !desc_stall)

endmodule

bind hid_descriptor_feature_scanner hdfs_checker u_checker (.*);

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives HID report descriptors into the feature scanner one word at a time,
// predicts the per-descriptor result alongside, and checks every result word.
// A short directed table covers prefix extremes and item shapes. Randomized
// descriptors follow under several sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hdfs_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_WORDS  = 1750;
  localparam int DRAIN_CYCLES  = 8;

  // One directed row: the word, and a hand-typed expectation where obvious
  typedef struct packed {
    desc_t   word;
    logic    typed;
    result_t want;
  } stim_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    desc_valid = 1'b0;
  logic    desc_stall;
  desc_t   desc = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      failures = 0;
  int      cycle_count = 0;
  int      words_sent = 0;

  // Predicted descriptor walker state
  logic [1:0] walk_phase = PH_PREFIX;
  logic [7:0] skip_left = '0;
  logic       feature_latched = 1'b0;

  result_t    pending_results[$];
  logic [7:0] desc_bytes[$];

  stim_row_t directed_rows [24] = '{
    '{'{8'hB0, 1'b1}, 1'b1, '{1'b1, 1'b0}},  // bare Feature prefix
    '{'{8'hB3, 1'b1}, 1'b1, '{1'b1, 1'b0}},  // Feature with data missing
    '{'{8'h00, 1'b1}, 1'b1, '{1'b0, 1'b0}},  // lowest byte, no data
    '{'{8'hFF, 1'b1}, 1'b1, '{1'b0, 1'b1}},  // highest byte, owes 4 data
    '{'{8'hFE, 1'b1}, 1'b1, '{1'b0, 1'b1}},  // long prefix alone
    '{'{8'hFE, 1'b0}, 1'b0, '0},             // zero-length long item
    '{'{8'h00, 1'b0}, 1'b0, '0},
    '{'{8'hB0, 1'b1}, 1'b0, '0},
    '{'{8'hFE, 1'b0}, 1'b0, '0},             // long item, Feature-like data
    '{'{8'h02, 1'b0}, 1'b0, '0},
    '{'{8'hB0, 1'b0}, 1'b0, '0},
    '{'{8'hB1, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b1}, 1'b0, '0},
    '{'{8'h05, 1'b0}, 1'b0, '0},             // short data that looks like Feature
    '{'{8'hB0, 1'b0}, 1'b0, '0},
    '{'{8'h0A, 1'b1}, 1'b0, '0},
    '{'{8'hB1, 1'b0}, 1'b0, '0},             // words after Feature are ignored
    '{'{8'hFE, 1'b0}, 1'b0, '0},
    '{'{8'hFF, 1'b1}, 1'b0, '0},
    '{'{8'hFE, 1'b0}, 1'b0, '0},             // longest long item, cut short
    '{'{8'hFF, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b1}, 1'b0, '0},
    '{'{8'hB4, 1'b0}, 1'b0, '0},             // tag B but not a Main item
    '{'{8'hC0, 1'b1}, 1'b0, '0}
  };

  hid_descriptor_feature_scanner dut (
    .clk          (clk),
    .rst          (rst),
    .desc_valid   (desc_valid),
    .desc_stall   (desc_stall),
    .desc         (desc),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the predicted walker by one word; return 1 when a result is due
  function automatic bit scan_descriptor_word(input desc_t w, output result_t r);
    logic [7:0] item_len;
    r = '0;
    if (!feature_latched) begin
      case (walk_phase)
        PH_PREFIX: begin
          if (w.desc_byte == LONG_PREFIX) begin
            walk_phase = PH_LONG_LEN;
          end else begin
            item_len = (w.desc_byte[1:0] == 2'd3) ? 8'd4 : {6'd0, w.desc_byte[1:0]};
            if (w.desc_byte[3:2] == TYPE_MAIN && w.desc_byte[7:4] == TAG_FEATURE) begin
              feature_latched = 1'b1;
            end else if (item_len != 0) begin
              skip_left = item_len;
              walk_phase = PH_DATA;
            end
          end
        end
        PH_LONG_LEN: begin
          skip_left = w.desc_byte;
          walk_phase = PH_LONG_TAG;
        end
        PH_LONG_TAG: begin
          walk_phase = (skip_left != 0) ? PH_DATA : PH_PREFIX;
        end
        default: begin
          if (skip_left > 1) begin
            skip_left = skip_left - 8'd1;
          end else begin
            skip_left = '0;
            walk_phase = PH_PREFIX;
          end
        end
      endcase
    end
    if (!w.last_byte) return 1'b0;
    r.has_feature = feature_latched;
    r.ended_inside_item = !feature_latched && walk_phase != PH_PREFIX;
    walk_phase = PH_PREFIX;
    skip_left = '0;
    feature_latched = 1'b0;
    return 1'b1;
  endfunction

  // Offer one word, hold it through stalls, then record its expected result
  task automatic send_word(input desc_t w, input logic typed, input result_t want);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      desc_valid <= 1'b0;
      @(posedge clk);
    end
    desc <= w;
    desc_valid <= 1'b1;
    @(posedge clk);
    while (desc_stall) @(posedge clk);
    words_sent++;
    if (scan_descriptor_word(w, r)) pending_results = {pending_results, typed ? want : r};
  endtask

  // Append n random data bytes
  task automatic add_data(input int n);
    for (int i = 0; i < n; i++) desc_bytes = {desc_bytes, 8'($urandom_range(255))};
  endtask

  // Build one random descriptor into desc_bytes: mostly well-formed items,
  // some pure noise, some cut off inside an item
  task automatic build_descriptor();
    int kind;
    int n_items;
    int pick;
    int len;
    logic [7:0] prefix;
    desc_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 10) begin
      add_data($urandom_range(1, 12));
    end else begin
      n_items = $urandom_range(1, 6);
      for (int i = 0; i < n_items; i++) begin
        pick = $urandom_range(99);
        if (pick < 12) begin
          prefix = {TAG_FEATURE, TYPE_MAIN, 2'($urandom_range(3))};
          desc_bytes = {desc_bytes, prefix};
          add_data(prefix[1:0] == 2'd3 ? 4 : int'(prefix[1:0]));
        end else if (pick < 30) begin
          len = ($urandom_range(39) == 0) ? $urandom_range(255) : $urandom_range(6);
          desc_bytes = {desc_bytes, LONG_PREFIX};
          desc_bytes = {desc_bytes, 8'(len)};
          add_data(1 + len);
        end else begin
          do prefix = 8'($urandom_range(255)); while (prefix == LONG_PREFIX);
          desc_bytes = {desc_bytes, prefix};
          add_data(prefix[1:0] == 2'd3 ? 4 : int'(prefix[1:0]));
        end
      end
      // Cut short so the descriptor may end inside an item
      if ($urandom_range(99) < 15) begin
        len = $urandom_range(1, desc_bytes.size());
        while (desc_bytes.size() > len) void'(desc_bytes.pop_back());
      end
    end
  endtask

  // Receiver: stall at random, check each accepted result word
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result word: has_feature=%0b ended_inside_item=%0b",
                 result.has_feature, result.ended_inside_item);
          failures++;
        end else begin
          want = pending_results.pop_front();
          if (result.has_feature !== want.has_feature) begin
            $error("has_feature: expected %0b, actual %0b",
                   want.has_feature, result.has_feature);
            failures++;
          end
          if (result.ended_inside_item !== want.ended_inside_item) begin
            $error("ended_inside_item: expected %0b, actual %0b",
                   want.ended_inside_item, result.ended_inside_item);
            failures++;
          end
        end
      end
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    int send_mix [4];
    int stall_mix [4];
    desc_t w;
    send_mix = '{0, 82, 0, 20};
    stall_mix = '{0, 0, 82, 20};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    foreach (directed_rows[i]) send_word(directed_rows[i].word, directed_rows[i].typed,
                                         directed_rows[i].want);

    // Random descriptors under each idle/stall mix
    for (int p = 0; p < 4; p++) begin
      desc_valid <= 1'b0;
      // Hold off the sender until every expected result is back
      while (pending_results.size() != 0) @(posedge clk);
      send_idle_pct = send_mix[p];
      recv_stall_pct = stall_mix[p];
      while (words_sent < 24 + (p + 1) * (RANDOM_WORDS / 4)) begin
        build_descriptor();
        foreach (desc_bytes[i]) begin
          w.desc_byte = desc_bytes[i];
          w.last_byte = (i == desc_bytes.size() - 1);
          send_word(w, 1'b0, '0);
        end
      end
    end
    desc_valid <= 1'b0;

    // Drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
